@@ rtl/core/trf_pkg.sv @@
`timescale 1ns / 1ps

package trf_pkg;

  // default sizes
  localparam int unsigned READ_CAPACITY_DEF  = 256;
  localparam int unsigned MAX_UNIT_BOUND_DEF = 10;

  // records per read
  localparam int unsigned MAX_RECORDS = 64;
  localparam int unsigned KW          = $clog2(MAX_RECORDS + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_UNIT_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_MIN_REPEAT_LENGTH = 2'd1;
  localparam logic [1:0] CFG_ALLOWED_GAP       = 2'd2;

  // configuration reset values
  localparam logic [3:0] MAX_UNIT_LENGTH_RST   = 4'd10;
  localparam logic [7:0] MIN_REPEAT_LENGTH_RST = 8'd4;
  localparam logic [7:0] ALLOWED_GAP_RST       = 8'd20;

  // result field widths
  localparam int unsigned POS_W  = 9;
  localparam int unsigned UNIT_W = 4;
  localparam int unsigned LEN_W  = 8;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_POS,
    ST_UNIT,
    ST_FETCH,
    ST_CHECK,
    ST_EVAL,
    ST_EMIT,
    ST_FINISH
  } state_t;

  // commands to the extension unit
  typedef struct packed {
    logic init;
    logic step;
  } ext_cmd_t;

  // status from the extension unit
  typedef struct packed {
    logic more;
    logic eq;
  } ext_flag_t;

  // one result record
  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  last_pos;
    logic [UNIT_W-1:0] unit_length;
    logic [POS_W-1:0]  unit_count;
    logic [LEN_W-1:0]  repeat_length;
    logic              final_record;
  } rec_t;

  // saturate to field maxima
  function automatic logic [POS_W-1:0] sat_pos(input logic [31:0] v);
    logic [31:0] lim;
    lim = (32'd1 << POS_W) - 32'd1;
    return (v > lim) ? lim[POS_W-1:0] : v[POS_W-1:0];
  endfunction

  function automatic logic [UNIT_W-1:0] sat_unit(input logic [31:0] v);
    logic [31:0] lim;
    lim = (32'd1 << UNIT_W) - 32'd1;
    return (v > lim) ? lim[UNIT_W-1:0] : v[UNIT_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(input logic [31:0] v);
    logic [31:0] lim;
    lim = (32'd1 << LEN_W) - 32'd1;
    return (v > lim) ? lim[LEN_W-1:0] : v[LEN_W-1:0];
  endfunction

endpackage

@@ rtl/core/trf_ram.sv @@
`timescale 1ns / 1ps

module trf_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/core/trf_ext.sv @@
`timescale 1ns / 1ps

module trf_ext #(
  parameter int unsigned READ_CAPACITY  = trf_pkg::READ_CAPACITY_DEF,
  parameter int unsigned MAX_UNIT_BOUND = trf_pkg::MAX_UNIT_BOUND_DEF
) (
  input  logic                                  clk,
  input  trf_pkg::ext_cmd_t                     cmd,
  input  logic [$clog2(READ_CAPACITY+2)-1:0]    pos,
  input  logic [$clog2(MAX_UNIT_BOUND+1)-1:0]   unit,
  input  logic [$clog2(READ_CAPACITY+2)-1:0]    n,
  input  logic [1:0]                            rd_a,
  input  logic [1:0]                            rd_b,
  output logic [$clog2(READ_CAPACITY)-1:0]      addr_a,
  output logic [$clog2(READ_CAPACITY)-1:0]      addr_b,
  output trf_pkg::ext_flag_t                    flags,
  output logic [$clog2(READ_CAPACITY+2)-1:0]    end_pos,
  output logic [$clog2(READ_CAPACITY+2)-1:0]    count,
  output logic [$clog2(READ_CAPACITY+2)-1:0]    len
);

  localparam int unsigned AW = $clog2(READ_CAPACITY);
  localparam int unsigned PW = $clog2(READ_CAPACITY + 2);
  localparam int unsigned UW = $clog2(MAX_UNIT_BOUND + 1);

  logic [PW-1:0] cur;
  logic [UW-1:0] phase;
  logic [UW-1:0] u;

  // run state: current position, phase inside the unit, whole copies, length
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cur   <= pos;
      phase <= '0;
      count <= PW'(1);
      len   <= '0;
      u     <= unit;
    end else if (cmd.step && flags.eq) begin
      cur <= PW'(32'(cur) + 32'd1);
      if (32'(phase) + 32'd1 == 32'(u)) begin
        phase <= '0;
        count <= PW'(32'(count) + 32'd1);
        len   <= PW'(32'(len) + 32'(u));
      end else begin
        phase <= UW'(32'(phase) + 32'd1);
      end
    end
  end

  // compare pair addresses and bounds
  assign addr_a     = AW'(32'(cur) - 32'd1);
  assign addr_b     = AW'(32'(cur) + 32'(u) - 32'd1);
  assign flags.more = (32'(cur) + 32'(u)) <= 32'(n);
  assign flags.eq   = (rd_a == rd_b);
  assign end_pos    = PW'(32'(cur) + 32'(u) - 32'd1);

endmodule

@@ rtl/core/trf_ctrl.sv @@
`timescale 1ns / 1ps

module trf_ctrl #(
  parameter int unsigned READ_CAPACITY  = trf_pkg::READ_CAPACITY_DEF,
  parameter int unsigned MAX_UNIT_BOUND = trf_pkg::MAX_UNIT_BOUND_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_base,
  input  logic                                in_last,
  input  logic [$clog2(MAX_UNIT_BOUND+1)-1:0] umax,
  input  logic [7:0]                          min_rep,
  input  logic [7:0]                          gap,
  output logic                                wr_en,
  output logic [$clog2(READ_CAPACITY)-1:0]    wr_addr,
  output logic [1:0]                          wr_data,
  output trf_pkg::ext_cmd_t                   cmd,
  output logic [$clog2(READ_CAPACITY+2)-1:0]  pos,
  output logic [$clog2(MAX_UNIT_BOUND+1)-1:0] unit,
  output logic [$clog2(READ_CAPACITY+2)-1:0]  n,
  input  trf_pkg::ext_flag_t                  flags,
  input  logic [$clog2(READ_CAPACITY+2)-1:0]  ext_end,
  input  logic [$clog2(READ_CAPACITY+2)-1:0]  ext_count,
  input  logic [$clog2(READ_CAPACITY+2)-1:0]  ext_len,
  output logic                                rec_valid,
  input  logic                                rec_ready,
  output trf_pkg::rec_t                       rec
);

  localparam int unsigned AW  = $clog2(READ_CAPACITY);
  localparam int unsigned PW  = $clog2(READ_CAPACITY + 2);
  localparam int unsigned UW  = $clog2(MAX_UNIT_BOUND + 1);
  localparam int unsigned UCW = UW + 1;
  localparam int unsigned KW  = trf_pkg::KW;

  trf_pkg::state_t state, state_next;
  logic [PW-1:0]   rl, rl_next;
  logic [PW-1:0]   pos_next;
  logic [PW-1:0]   prev_end, prev_end_next;
  logic [KW-1:0]   k, k_next;
  logic [UCW-1:0]  u, u_next;
  logic            hit, hit_next;
  logic [PW-1:0]   best_len, best_len_next;
  logic [PW-1:0]   best_end, best_end_next;
  logic [UW-1:0]   best_unit, best_unit_next;
  logic [PW-1:0]   best_count, best_count_next;
  logic            pend_valid, pend_valid_next;
  trf_pkg::rec_t   pend, pend_next;
  trf_pkg::rec_t   new_rec;
  logic            in_req;
  logic            pos_ok;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= trf_pkg::ST_LOAD;
      rl         <= '0;
      pos        <= PW'(1);
      prev_end   <= '0;
      k          <= '0;
      u          <= '0;
      hit        <= 1'b0;
      best_len   <= '0;
      best_end   <= '0;
      best_unit  <= '0;
      best_count <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      rl         <= rl_next;
      pos        <= pos_next;
      prev_end   <= prev_end_next;
      k          <= k_next;
      u          <= u_next;
      hit        <= hit_next;
      best_len   <= best_len_next;
      best_end   <= best_end_next;
      best_unit  <= best_unit_next;
      best_count <= best_count_next;
      pend_valid <= pend_valid_next;
    end
  end

  // pending record payload
  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  assign in_ready = (state == trf_pkg::ST_LOAD);
  assign in_req   = in_valid && in_ready;
  assign n        = rl;
  assign unit     = UW'(u);

  // store writes while the read loads
  assign wr_en   = in_req && (32'(rl) < READ_CAPACITY);
  assign wr_addr = AW'(rl);
  assign wr_data = in_base;

  // a start position is still searched
  assign pos_ok = (32'(pos) <= 32'(rl)) &&
                  ((prev_end == '0) || (32'(pos) <= 32'(prev_end) + 32'(gap)));

  // record for the best run at this position
  always_comb begin
    new_rec               = '0;
    new_rec.found         = 1'b1;
    new_rec.first_pos     = trf_pkg::sat_pos(32'(pos));
    new_rec.last_pos      = trf_pkg::sat_pos(32'(best_end));
    new_rec.unit_length   = trf_pkg::sat_unit(32'(best_unit));
    new_rec.unit_count    = trf_pkg::sat_pos(32'(best_count));
    new_rec.repeat_length = trf_pkg::sat_len(32'(best_len));
  end

  // next state, run control and record hand-off
  always_comb begin
    state_next      = state;
    rl_next         = rl;
    pos_next        = pos;
    prev_end_next   = prev_end;
    k_next          = k;
    u_next          = u;
    hit_next        = hit;
    best_len_next   = best_len;
    best_end_next   = best_end;
    best_unit_next  = best_unit;
    best_count_next = best_count;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    cmd             = '0;
    rec_valid       = 1'b0;
    rec             = pend;

    case (state)
      trf_pkg::ST_LOAD: begin
        if (in_req) begin
          if (32'(rl) < READ_CAPACITY) begin
            rl_next = PW'(32'(rl) + 32'd1);
          end
          if (in_last) begin
            pos_next        = PW'(1);
            prev_end_next   = '0;
            k_next          = '0;
            pend_valid_next = 1'b0;
            state_next      = trf_pkg::ST_POS;
          end
        end
      end

      trf_pkg::ST_POS: begin
        if (pos_ok) begin
          hit_next        = 1'b0;
          best_len_next   = '0;
          best_end_next   = '0;
          best_unit_next  = '0;
          best_count_next = '0;
          u_next          = UCW'(1);
          state_next      = trf_pkg::ST_UNIT;
        end else begin
          state_next = trf_pkg::ST_FINISH;
        end
      end

      trf_pkg::ST_UNIT: begin
        if (32'(u) > 32'(umax)) begin
          if (hit) begin
            state_next = trf_pkg::ST_EMIT;
          end else begin
            pos_next   = PW'(32'(pos) + 32'd1);
            state_next = trf_pkg::ST_POS;
          end
        end else begin
          cmd.init   = 1'b1;
          state_next = trf_pkg::ST_FETCH;
        end
      end

      // store reads are issued here and come back in the check state
      trf_pkg::ST_FETCH: begin
        if (flags.more) begin
          state_next = trf_pkg::ST_CHECK;
        end else begin
          state_next = trf_pkg::ST_EVAL;
        end
      end

      trf_pkg::ST_CHECK: begin
        cmd.step = 1'b1;
        if (flags.eq) begin
          state_next = trf_pkg::ST_FETCH;
        end else begin
          state_next = trf_pkg::ST_EVAL;
        end
      end

      // keep the longest run, shortest unit on a tie
      trf_pkg::ST_EVAL: begin
        if ((32'(ext_len) >= 32'(min_rep)) && (ext_len > best_len)) begin
          hit_next        = 1'b1;
          best_len_next   = ext_len;
          best_end_next   = ext_end;
          best_unit_next  = UW'(u);
          best_count_next = ext_count;
        end
        u_next     = UCW'(32'(u) + 32'd1);
        state_next = trf_pkg::ST_UNIT;
      end

      // hold the new record; the one before it goes out as not final
      trf_pkg::ST_EMIT: begin
        rec_valid = pend_valid;
        if (!pend_valid || rec_ready) begin
          pend_valid_next = 1'b1;
          pend_next       = new_rec;
          k_next          = KW'(32'(k) + 32'd1);
          prev_end_next   = best_end;
          pos_next        = PW'(32'(best_end) + 32'd1);
          if (32'(k) + 32'd1 >= trf_pkg::MAX_RECORDS) begin
            state_next = trf_pkg::ST_FINISH;
          end else begin
            state_next = trf_pkg::ST_POS;
          end
        end
      end

      // last record of the read, or the none-found record
      trf_pkg::ST_FINISH: begin
        rec_valid = 1'b1;
        if (pend_valid) begin
          rec              = pend;
          rec.final_record = 1'b1;
        end else begin
          rec              = '0;
          rec.final_record = 1'b1;
        end
        if (rec_ready) begin
          rl_next         = '0;
          pos_next        = PW'(1);
          prev_end_next   = '0;
          k_next          = '0;
          pend_valid_next = 1'b0;
          hit_next        = 1'b0;
          best_len_next   = '0;
          best_end_next   = '0;
          best_unit_next  = '0;
          best_count_next = '0;
          state_next      = trf_pkg::ST_LOAD;
        end
      end

      default: begin
        state_next = trf_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/core/tandem_repeat_finder_core.sv @@
`timescale 1ns / 1ps

// Tandem repeat finder.
// Input stream: one base per request, code in s_tdata[1:0], s_tlast on the
// final base of a read. Bases load at one per cycle; bases beyond
// READ_CAPACITY are dropped. After the final base, s_tready stays low while
// the read is searched, and rises again once the last record is in the
// output register.
// Output stream: one request per repeat found, in position order, m_tlast on
// the last record of the read; a read with no repeat gives one record with
// m_tuser low and all other fields zero. At most 64 records per read.
// Search: every start position is tried with each unit length u up to
// max_unit_length; each base pair compare takes a store read state and a
// check state on the shared extension unit. Each record found passes a
// hand-off state, and the last record of the read a finish state.
// Receiver stall: one record waits in the output register and one more is
// held inside; the search pauses while both are full.
// Reset (rst, synchronous): configuration returns to max_unit_length 10,
// min_repeat_length 4, allowed_gap 20; the block waits for a new read.

module tandem_repeat_finder_core #(
  parameter int unsigned READ_CAPACITY  = trf_pkg::READ_CAPACITY_DEF,
  parameter int unsigned MAX_UNIT_BOUND = trf_pkg::MAX_UNIT_BOUND_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] base, [7:2] zero
  input  logic        s_tlast,   // read_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // first_pos, last_pos, unit_length, unit_count,
                                 // repeat_length, zero pad
  output logic [0:0]  m_tuser,   // found
  output logic        m_tlast,   // final_record
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned AW = $clog2(READ_CAPACITY);
  localparam int unsigned PW = $clog2(READ_CAPACITY + 2);
  localparam int unsigned UW = $clog2(MAX_UNIT_BOUND + 1);

  logic [3:0]         max_unit_length;
  logic [7:0]         min_repeat_length;
  logic [7:0]         allowed_gap;
  logic [UW-1:0]      umax;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [1:0]         wr_data;
  logic [AW-1:0]      addr_a;
  logic [AW-1:0]      addr_b;
  logic [1:0]         rd_a;
  logic [1:0]         rd_b;

  trf_pkg::ext_cmd_t  cmd;
  trf_pkg::ext_flag_t flags;
  logic [PW-1:0]      pos;
  logic [UW-1:0]      unit;
  logic [PW-1:0]      n;
  logic [PW-1:0]      ext_end;
  logic [PW-1:0]      ext_count;
  logic [PW-1:0]      ext_len;

  logic               rec_valid;
  logic               rec_ready;
  trf_pkg::rec_t      rec;
  trf_pkg::rec_t      out_rec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_unit_length   <= trf_pkg::MAX_UNIT_LENGTH_RST;
      min_repeat_length <= trf_pkg::MIN_REPEAT_LENGTH_RST;
      allowed_gap       <= trf_pkg::ALLOWED_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        trf_pkg::CFG_MAX_UNIT_LENGTH:   max_unit_length   <= cfg_data[3:0];
        trf_pkg::CFG_MIN_REPEAT_LENGTH: min_repeat_length <= cfg_data;
        trf_pkg::CFG_ALLOWED_GAP:       allowed_gap       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // clamp the unit limit to what the unit counter supports
  always_comb begin
    if (32'(max_unit_length) > MAX_UNIT_BOUND) begin
      umax = UW'(MAX_UNIT_BOUND);
    end else begin
      umax = UW'(max_unit_length);
    end
  end

  // base store
  trf_ram #(
    .WIDTH (2),
    .DEPTH (READ_CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // shared run extension unit
  trf_ext #(
    .READ_CAPACITY  (READ_CAPACITY),
    .MAX_UNIT_BOUND (MAX_UNIT_BOUND)
  ) u_ext (
    .clk     (clk),
    .cmd     (cmd),
    .pos     (pos),
    .unit    (unit),
    .n       (n),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .addr_a  (addr_a),
    .addr_b  (addr_b),
    .flags   (flags),
    .end_pos (ext_end),
    .count   (ext_count),
    .len     (ext_len)
  );

  // sequencer
  trf_ctrl #(
    .READ_CAPACITY  (READ_CAPACITY),
    .MAX_UNIT_BOUND (MAX_UNIT_BOUND)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_base   (s_tdata[1:0]),
    .in_last   (s_tlast),
    .umax      (umax),
    .min_rep   (min_repeat_length),
    .gap       (allowed_gap),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .cmd       (cmd),
    .pos       (pos),
    .unit      (unit),
    .n         (n),
    .flags     (flags),
    .ext_end   (ext_end),
    .ext_count (ext_count),
    .ext_len   (ext_len),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  // output register
  assign rec_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rec_ready) begin
      m_tvalid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) begin
      out_rec <= rec;
    end
  end

  assign m_tdata = {1'b0, out_rec.repeat_length, out_rec.unit_count,
                    out_rec.unit_length, out_rec.last_pos, out_rec.first_pos};
  assign m_tuser = out_rec.found;
  assign m_tlast = out_rec.final_record;

endmodule
